// ----- src/ucdp_pkg.sv -----
package ucdp_pkg;

   // descriptor type codes that produce a record
   localparam logic [7:0] DESC_CONFIG    = 8'd2;
   localparam logic [7:0] DESC_INTERFACE = 8'd4;
   localparam logic [7:0] DESC_ENDPOINT  = 8'd5;
   localparam logic [7:0] DESC_HID       = 8'd33;

   localparam logic [7:0] MIN_DESC_LENGTH = 8'd2;
   localparam logic [7:0] LAST_CAPTURE_OFFSET = 8'd9;

   localparam int RSP_DATA_WIDTH = 88;

   typedef enum logic [2:0] {
      KIND_CONFIG    = 3'd0,
      KIND_INTERFACE = 3'd1,
      KIND_ENDPOINT  = 3'd2,
      KIND_HID       = 3'd3,
      KIND_ERROR     = 3'd4
   } record_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_NO_CONFIG    = 3'd1,
      ERR_TOO_MANY_IF  = 3'd2,
      ERR_NO_INTERFACE = 3'd3,
      ERR_TOO_MANY_EP  = 3'd4,
      ERR_LENGTH       = 3'd5
   } error_code_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_beat_type;

   typedef struct packed {
      record_kind_type kind;
      error_code_type  err;
      logic [7:0]      ordinal;
      logic [7:0]      ident;
      logic [7:0]      child_count;
      logic [7:0]      class_code;
      logic [7:0]      subclass_code;
      logic [7:0]      protocol_code;
      logic [7:0]      attributes;
      logic [15:0]     word_value;
      logic [7:0]      poll_interval;
      logic            block_done;
   } record_type;

endpackage

// ----- src/ucdp_input_stage.sv -----
module ucdp_input_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  ucdp_pkg::byte_beat_type in_beat,
   output logic                   stage_valid,
   input  logic                   stage_advance,
   output ucdp_pkg::byte_beat_type stage_beat
);
   import ucdp_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   byte_beat_type beat_ff;

   // holding register frees up whenever the core consumes it
   assign in_ready = !valid_ff || stage_advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= in_beat;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_beat  = beat_ff;

endmodule

// ----- src/ucdp_parse_core.sv -----
module ucdp_parse_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ucdp_pkg::byte_beat_type beat,
   output logic                   rec_valid,
   output ucdp_pkg::record_type    rec
);
   import ucdp_pkg::*;

   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  type_ff, type_in;
   logic [63:0] capture_ff, capture_in;
   logic        have_config_ff, have_config_in;
   logic        have_if_ff, have_if_in;
   logic [7:0]  if_announced_ff, if_announced_in;
   logic [8:0]  if_seen_ff, if_seen_in;
   logic [7:0]  ep_announced_ff, ep_announced_in;
   logic [8:0]  ep_seen_ff, ep_seen_in;
   logic        failed_ff, failed_in;

   error_code_type err;
   record_type     rec_c;
   logic           emit;
   logic [2:0]     cap_idx;

   // offsets 2..9 map to capture byte 0..7
   assign cap_idx = offset_ff[2:0] - 3'd2;

   always_comb begin
      offset_in       = offset_ff;
      length_in       = length_ff;
      type_in         = type_ff;
      capture_in      = capture_ff;
      have_config_in  = have_config_ff;
      have_if_in      = have_if_ff;
      if_announced_in = if_announced_ff;
      if_seen_in      = if_seen_ff;
      ep_announced_in = ep_announced_ff;
      ep_seen_in      = ep_seen_ff;
      failed_in       = failed_ff;
      err             = ERR_NONE;
      rec_c           = '0;
      emit            = 1'b0;

      if (step) begin
         if (failed_ff) begin
            // drop everything until the block ends
         end else if (offset_ff == 8'd0) begin
            length_in  = beat.data;
            capture_in = '0;
            if (beat.data < MIN_DESC_LENGTH) begin
               err = ERR_LENGTH;
            end else begin
               offset_in = 8'd1;
               if (beat.last) begin
                  err = ERR_LENGTH;
               end
            end
         end else begin
            if (offset_ff == 8'd1) begin
               type_in = beat.data;
            end else if (offset_ff <= LAST_CAPTURE_OFFSET) begin
               capture_in[{cap_idx, 3'b000} +: 8] = beat.data;
            end

            if (({1'b0, offset_ff} + 9'd1) != {1'b0, length_ff}) begin
               offset_in = offset_ff + 8'd1;
               if (beat.last) begin
                  err = ERR_LENGTH;
               end
            end else begin
               // last byte of the descriptor
               offset_in = 8'd0;
               case (type_in)
                  DESC_CONFIG: begin
                     have_config_in      = 1'b1;
                     if_announced_in     = capture_in[23:16];
                     if_seen_in          = 9'd0;
                     rec_c.kind          = KIND_CONFIG;
                     rec_c.ident         = capture_in[31:24];
                     rec_c.child_count   = capture_in[23:16];
                     rec_c.word_value    = capture_in[15:0];
                     emit                = 1'b1;
                  end
                  DESC_INTERFACE: begin
                     if (!have_config_ff) begin
                        err = ERR_NO_CONFIG;
                     end else if (if_seen_ff >= {1'b0, if_announced_ff}) begin
                        err = ERR_TOO_MANY_IF;
                     end else begin
                        rec_c.kind          = KIND_INTERFACE;
                        rec_c.ordinal       = if_seen_ff[7:0];
                        rec_c.ident         = capture_in[7:0];
                        rec_c.child_count   = capture_in[23:16];
                        rec_c.class_code    = capture_in[31:24];
                        rec_c.subclass_code = capture_in[39:32];
                        rec_c.protocol_code = capture_in[47:40];
                        if_seen_in          = if_seen_ff + 9'd1;
                        have_if_in          = 1'b1;
                        ep_announced_in     = capture_in[23:16];
                        ep_seen_in          = 9'd0;
                        emit                = 1'b1;
                     end
                  end
                  DESC_ENDPOINT: begin
                     if (!have_if_ff) begin
                        err = ERR_NO_INTERFACE;
                     end else if (ep_seen_ff >= {1'b0, ep_announced_ff}) begin
                        err = ERR_TOO_MANY_EP;
                     end else begin
                        rec_c.kind          = KIND_ENDPOINT;
                        rec_c.ordinal       = ep_seen_ff[7:0];
                        rec_c.ident         = capture_in[7:0];
                        rec_c.attributes    = capture_in[15:8];
                        rec_c.word_value    = capture_in[31:16];
                        rec_c.poll_interval = capture_in[39:32];
                        ep_seen_in          = ep_seen_ff + 9'd1;
                        emit                = 1'b1;
                     end
                  end
                  DESC_HID: begin
                     if (!have_config_ff) begin
                        err = ERR_NO_CONFIG;
                     end else begin
                        rec_c.kind       = KIND_HID;
                        rec_c.ident      = capture_in[39:32];
                        rec_c.word_value = capture_in[55:40];
                        emit             = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         if (err != ERR_NONE) begin
            rec_c      = '0;
            rec_c.kind = KIND_ERROR;
            rec_c.err  = err;
            emit       = 1'b1;
            failed_in  = 1'b1;
         end
         rec_c.block_done = beat.last;

         // every path returns to the idle state at the end of a block
         if (beat.last) begin
            offset_in       = '0;
            length_in       = '0;
            type_in         = '0;
            capture_in      = '0;
            have_config_in  = 1'b0;
            have_if_in      = 1'b0;
            if_announced_in = '0;
            if_seen_in      = '0;
            ep_announced_in = '0;
            ep_seen_in      = '0;
            failed_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff       <= '0;
         length_ff       <= '0;
         type_ff         <= '0;
         capture_ff      <= '0;
         have_config_ff  <= 1'b0;
         have_if_ff      <= 1'b0;
         if_announced_ff <= '0;
         if_seen_ff      <= '0;
         ep_announced_ff <= '0;
         ep_seen_ff      <= '0;
         failed_ff       <= 1'b0;
      end else begin
         offset_ff       <= offset_in;
         length_ff       <= length_in;
         type_ff         <= type_in;
         capture_ff      <= capture_in;
         have_config_ff  <= have_config_in;
         have_if_ff      <= have_if_in;
         if_announced_ff <= if_announced_in;
         if_seen_ff      <= if_seen_in;
         ep_announced_ff <= ep_announced_in;
         ep_seen_ff      <= ep_seen_in;
         failed_ff       <= failed_in;
      end
   end

   assign rec_valid = emit;
   assign rec       = rec_c;

endmodule

// ----- src/ucdp_output_stage.sv -----
module ucdp_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                rec_valid,
   input  ucdp_pkg::record_type rec,
   output logic                load_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output ucdp_pkg::record_type out_rec
);
   import ucdp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   record_type rec_ff;

   // loads whenever the held record is empty or leaving this cycle
   assign load_ready = !valid_ff || out_ready;
   assign valid_in   = load_ready ? rec_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && rec_valid) begin
         rec_ff <= rec;
      end
   end

   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

endmodule

// ----- src/usb_config_descriptor_parser_unit.sv -----
// USB configuration descriptor parser
// The req channel carries the descriptor block, one byte per beat: tdata is the
// byte and tlast marks the final byte of the whole block. On the last byte of a
// configuration, interface, endpoint or HID descriptor one record leaves on the
// rsp channel; other descriptors are skipped silently. Structural faults (no
// configuration, no interface, count overrun, bad length, truncated block)
// give one error record, after which the rest of the block is dropped.
// rsp tuser carries the record kind; rsp tlast is set on a record produced by
// the final byte of the block.
// Timing: one byte register and one record register with the parse logic
// between them, so a record is offered on rsp once its byte has passed the
// byte register and the parse logic has loaded the record register.
// Throughput is one byte per cycle while the record register can load.
// When rsp_tready is low with a record held, that register holds and an empty
// byte register takes one more beat; req_tready drops until the record leaves.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of a block; a block always restarts after its tlast.
module usb_config_descriptor_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tlast,   // end_of_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] error_code, [10:3] ordinal, [18:11] ident, [26:19] child_count,
   // [34:27] class_code, [42:35] subclass_code, [50:43] protocol_code,
   // [58:51] attributes, [74:59] word_value, [82:75] poll_interval,
   // [87:83] zero
   output logic [ucdp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] record_kind
   output logic        rsp_tlast    // block_done
);
   import ucdp_pkg::*;

   byte_beat_type in_beat;
   byte_beat_type stage_beat;
   logic          stage_valid;
   logic          load_ready;
   logic          step;
   logic          rec_valid;
   record_type    rec;
   record_type    out_rec;

   assign in_beat.data = req_tdata;
   assign in_beat.last = req_tlast;
   assign step         = stage_valid && load_ready;

   ucdp_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_beat       (in_beat),
      .stage_valid   (stage_valid),
      .stage_advance (load_ready),
      .stage_beat    (stage_beat)
   );

   ucdp_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .beat      (stage_beat),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   ucdp_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .rec_valid  (rec_valid),
      .rec        (rec),
      .load_ready (load_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rec    (out_rec)
   );

   assign rsp_tdata = {5'b00000,
                       out_rec.poll_interval,
                       out_rec.word_value,
                       out_rec.attributes,
                       out_rec.protocol_code,
                       out_rec.subclass_code,
                       out_rec.class_code,
                       out_rec.child_count,
                       out_rec.ident,
                       out_rec.ordinal,
                       out_rec.err};
   assign rsp_tuser = out_rec.kind;
   assign rsp_tlast = out_rec.block_done;

endmodule
